// ===== rtl/core/reb_pkg.sv =====
// reb_pkg: shared types and constants for the rotary encoder with button unit
// used by reb_tick, rotary_encoder_with_button_unit, reb_checker and the bench, no dependencies

package reb_pkg;

	localparam int unsigned SHIFT_W    = 2;
	localparam int unsigned INTERVAL_W = 10;
	localparam int unsigned ACCUM_W    = 8;
	localparam int unsigned CFG_ADDR_W = 1;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 8;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd20;
	localparam logic [INTERVAL_W-1:0] TICK_MAX       = 10'd1023;
	localparam logic [SHIFT_W-1:0]    SHIFT_UNUSED   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_NOTCH_SHIFT     = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_BUTTON_INTERVAL = 1'b1;

	typedef enum logic [1:0] {
		KEY_OPEN    = 2'd0,
		KEY_HELD    = 2'd1,
		KEY_CLICKED = 2'd2
	} key_state_t;

	localparam logic signed [1:0] DIR_NONE = 2'sd0;
	localparam logic signed [1:0] DIR_UP   = 2'sd1;
	localparam logic signed [1:0] DIR_DOWN = -2'sd1;

	typedef struct packed {
		logic take_button;
		logic take_value;
		logic key_low;
		logic pin_b_low;
		logic pin_a_low;
	} tick_t;

	typedef struct packed {
		logic [1:0]        button_code;
		logic signed [1:0] step_dir;
	} result_t;

endpackage

// ===== rtl/core/reb_tick.sv =====
// reb_tick: per-tick encoder, button and read update with its state registers
// depends on reb_pkg

module reb_tick (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  reb_pkg::tick_t                    tick,
	input  logic [reb_pkg::SHIFT_W-1:0]       notch_shift,
	input  logic [reb_pkg::INTERVAL_W-1:0]    button_interval,
	output reb_pkg::result_t                  result
);

	logic [1:0]                        prev_phase_q;
	logic [reb_pkg::ACCUM_W-1:0]       step_accum_q;
	reb_pkg::key_state_t               key_state_q;
	logic [reb_pkg::INTERVAL_W-1:0]    ticks_q;

	logic [1:0]                        phase;
	logic [1:0]                        diff;
	logic [reb_pkg::ACCUM_W-1:0]       accum_step;
	logic [reb_pkg::ACCUM_W-1:0]       accum_next;
	logic [reb_pkg::ACCUM_W-1:0]       notch_lim;
	logic [reb_pkg::SHIFT_W-1:0]       sh;
	logic [reb_pkg::INTERVAL_W-1:0]    ticks_inc;
	logic [reb_pkg::INTERVAL_W-1:0]    ticks_next;
	logic                              sample;
	reb_pkg::key_state_t               key_tick;
	reb_pkg::key_state_t               key_next;
	logic [1:0]                        phase_next;

	always_comb begin
		// gray phase: pin a low gives 3, pin b low flips bit 0
		phase = {tick.pin_a_low, tick.pin_a_low ^ tick.pin_b_low};
		diff  = prev_phase_q - phase;

		phase_next = prev_phase_q;
		accum_step = step_accum_q;
		if (diff[0]) begin
			phase_next = phase;
			accum_step = diff[1] ? step_accum_q + 8'd1 : step_accum_q - 8'd1;
		end

		ticks_inc  = (ticks_q == reb_pkg::TICK_MAX) ? ticks_q : ticks_q + 10'd1;
		sample     = (ticks_inc >= button_interval);
		ticks_next = sample ? '0 : ticks_inc;

		key_tick = key_state_q;
		if (sample) begin
			if (tick.key_low) begin
				key_tick = reb_pkg::KEY_HELD;
			end else if (key_state_q == reb_pkg::KEY_HELD) begin
				key_tick = reb_pkg::KEY_CLICKED;
			end
		end

		sh        = (notch_shift == reb_pkg::SHIFT_UNUSED) ? '0 : notch_shift;
		notch_lim = 8'd1 << sh;

		result.step_dir = reb_pkg::DIR_NONE;
		accum_next      = accum_step;
		if (tick.take_value) begin
			if (accum_step[reb_pkg::ACCUM_W-1]) begin
				result.step_dir = reb_pkg::DIR_DOWN;
			end else if (accum_step >= notch_lim) begin
				result.step_dir = reb_pkg::DIR_UP;
			end
			// keep the partial notch
			accum_next = accum_step & (notch_lim - 8'd1);
		end

		result.button_code = '0;
		key_next           = key_tick;
		if (tick.take_button) begin
			result.button_code = key_tick;
			if (key_tick != reb_pkg::KEY_HELD) begin
				key_next = reb_pkg::KEY_OPEN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_phase_q <= '0;
			step_accum_q <= '0;
			key_state_q  <= reb_pkg::KEY_OPEN;
			ticks_q      <= '0;
		end else if (en) begin
			prev_phase_q <= phase_next;
			step_accum_q <= accum_next;
			key_state_q  <= key_next;
			ticks_q      <= ticks_next;
		end
	end

endmodule

// ===== rtl/core/rotary_encoder_with_button_unit.sv =====
// rotary_encoder_with_button_unit: top level, stream ports, config registers
// depends on reb_pkg and reb_tick
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | s_tdata: one 1 ms tick of pins and requests
//  m_*     | out | m_tvalid/m_tready | m_tdata: step direction and button code
//  cfg_*   | in  | cfg_we            | cfg_addr, cfg_wdata
//
// one tick per cycle sustained while the output is not stalled; each tick is registered twice:
// the tick is held in an input stage, then the state update and result are
// computed in one pass and land in the output register
// a stalled output register holds the input stage, which takes one more tick only if empty
// reset clears encoder state, button state, counters and config registers to defaults

module rotary_encoder_with_button_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [0] pin_a_low, [1] pin_b_low, [2] key_low, [3] take_value, [4] take_button
	input  logic [reb_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1:0] step_dir (signed), [3:2] button_code
	output logic [reb_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic [reb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [reb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	logic [reb_pkg::SHIFT_W-1:0]       notch_shift_q;
	logic [reb_pkg::INTERVAL_W-1:0]    button_interval_q;

	logic                              valid_s1;
	reb_pkg::tick_t                    tick_s1;
	logic                              out_valid_q;
	reb_pkg::result_t                  out_q;
	reb_pkg::result_t                  result;
	logic                              advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notch_shift_q     <= '0;
			button_interval_q <= reb_pkg::INTERVAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				reb_pkg::REG_NOTCH_SHIFT:     notch_shift_q <= cfg_wdata[reb_pkg::SHIFT_W-1:0];
				reb_pkg::REG_BUTTON_INTERVAL: button_interval_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tick_s1 <= s_tdata[4:0];
		end
		if (advance) begin
			out_q <= result;
		end
	end

	reb_tick u_tick (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (advance),
		.tick            (tick_s1),
		.notch_shift     (notch_shift_q),
		.button_interval (button_interval_q),
		.result          (result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_q};

endmodule

// ===== rtl/core/reb_checker.sv =====
// reb_checker: port-level assertions for rotary_encoder_with_button_unit
// depends on reb_pkg; bound to the top level below

module reb_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [reb_pkg::OUT_DATA_W-1:0]    m_tdata
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// result codes stay in range and padding is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'b10) && (m_tdata[3:2] != 2'b11)
			&& (m_tdata[7:4] == 4'b0))
		else $error("result code out of range");

	// a free output side never blocks input
	assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with output free");

	// accepted tick reaches the output through the input stage when not stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
		else $error("accepted tick produced no result");

endmodule

bind rotary_encoder_with_button_unit reb_checker u_reb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/rotary_encoder_with_button_unit_tb.sv =====
// rotary_encoder_with_button_unit_tb: self-checking bench for the encoder/button unit
// predicts every readout from the ticks it sends, checks each readout request in order
// depends on reb_pkg and rotary_encoder_with_button_unit

module rotary_encoder_with_button_unit_tb;
	import reb_pkg::*;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	rotary_encoder_with_button_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// predicted unit state and register copies
	logic [SHIFT_W-1:0]    cur_shift    = '0;
	logic [INTERVAL_W-1:0] cur_interval = INTERVAL_RESET;
	logic [1:0]            enc_phase    = '0;
	logic [ACCUM_W-1:0]    step_count   = '0;
	key_state_t            button_state = KEY_OPEN;
	logic [INTERVAL_W-1:0] tick_count   = '0;

	tick_t   tick_queue[$];
	result_t due_readouts[$];
	int      mismatches = 0;
	int      tx_max = 0;
	int      rx_max = 0;
	int      tx_wait = 0;
	int      rx_wait = 0;
	int      tx_draw;
	int      rx_draw;

	// random tick generator state
	logic [1:0] gen_phase = '0;
	logic       gen_up = 1'b1;
	int         gen_run = 0;
	logic       gen_key = 1'b0;
	int         gen_key_run = 0;
	int         gen_read_pct = 30;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic result_t advance_tick(tick_t t);
		logic [1:0] phase;
		logic [1:0] diff;
		logic [1:0] sh;
		result_t    r;
		phase = t.pin_a_low ? 2'd3 : 2'd0;
		if (t.pin_b_low)
			phase[0] = ~phase[0];
		diff = enc_phase - phase;
		// odd difference is a real step, bit 1 picks the direction
		if (diff[0]) begin
			enc_phase = phase;
			step_count = diff[1] ? step_count + 8'd1 : step_count - 8'd1;
		end
		if (tick_count != TICK_MAX)
			tick_count = tick_count + 10'd1;
		if (tick_count >= cur_interval) begin
			tick_count = '0;
			if (t.key_low)
				button_state = KEY_HELD;
			else if (button_state == KEY_HELD)
				button_state = KEY_CLICKED;
		end
		r.step_dir = DIR_NONE;
		r.button_code = KEY_OPEN;
		if (t.take_value) begin
			sh = (cur_shift == SHIFT_UNUSED) ? 2'd0 : cur_shift;
			if (step_count[ACCUM_W-1])
				r.step_dir = DIR_DOWN;
			else if (int'(step_count) >= (1 << sh))
				r.step_dir = DIR_UP;
			step_count = step_count & ACCUM_W'((1 << sh) - 1);
		end
		if (t.take_button) begin
			r.button_code = button_state;
			if (button_state != KEY_HELD)
				button_state = KEY_OPEN;
		end
		return r;
	endfunction

	function automatic tick_t make_tick(logic [1:0] ph, logic key, logic tv, logic tb);
		tick_t t;
		// gray phase back to pins: 0 -> 00, 1 -> b, 2 -> ab, 3 -> a
		t.pin_a_low = ph[1];
		t.pin_b_low = ph[1] ^ ph[0];
		t.key_low = key;
		t.take_value = tv;
		t.take_button = tb;
		return t;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// driver: one tick request at a time, random gap drawn after each accepted tick
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			tx_wait <= 0;
		end else if (s_tvalid && s_tready) begin
			due_readouts.push_back(advance_tick(tick_t'(s_tdata[4:0])));
			tx_draw = $urandom_range(0, tx_max);
			if (tx_draw == 0 && tick_queue.size() != 0) begin
				s_tdata <= {3'b000, tick_queue.pop_front()};
			end else begin
				s_tvalid <= 1'b0;
				tx_wait <= tx_draw;
			end
		end else if (!s_tvalid) begin
			if (tx_wait != 0)
				tx_wait <= tx_wait - 1;
			else if (tick_queue.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= {3'b000, tick_queue.pop_front()};
			end
		end
	end

	// monitor: compares each readout with the oldest prediction, stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			if (due_readouts.size() == 0) begin
				report("unexpected readout", int'(m_tdata), 0);
			end else begin
				result_t want;
				want = due_readouts.pop_front();
				if ($signed(m_tdata[1:0]) != want.step_dir)
					report("step_dir", int'($signed(m_tdata[1:0])), int'(want.step_dir));
				if (m_tdata[3:2] != want.button_code)
					report("button_code", int'(m_tdata[3:2]), int'(want.button_code));
				if (m_tdata[OUT_DATA_W-1:4] != '0)
					report("tdata padding", int'(m_tdata[OUT_DATA_W-1:4]), 0);
			end
			rx_draw = $urandom_range(0, rx_max);
			if (rx_draw != 0) begin
				m_tready <= 1'b0;
				rx_wait <= rx_draw;
			end
		end else if (!m_tready) begin
			if (rx_wait > 1)
				rx_wait <= rx_wait - 1;
			else
				m_tready <= 1'b1;
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (tick_queue.size() != 0 || s_tvalid || due_readouts.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// writes both registers on back-to-back edges, only while the unit is idle
	task automatic apply_settings(logic [SHIFT_W-1:0] sh, logic [INTERVAL_W-1:0] iv);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_NOTCH_SHIFT;
		cfg_wdata <= CFG_DATA_W'(sh);
		@(posedge clk);
		cfg_addr <= REG_BUTTON_INTERVAL;
		cfg_wdata <= iv;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_shift = sh;
		cur_interval = iv;
	endtask

	// mostly clean rotation runs with random reads, some holds and gray jumps
	task automatic queue_random_ticks(int count);
		int  pick;
		logic tv;
		logic tb;
		for (int i = 0; i < count; i++) begin
			if (gen_run == 0) begin
				gen_up = 1'($urandom_range(0, 1));
				gen_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				                                      : $urandom_range(1, 30);
				gen_read_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
			end
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				gen_phase = gen_up ? gen_phase + 2'd1 : gen_phase - 2'd1;
				gen_run--;
			end else if (pick >= 90) begin
				gen_phase = gen_phase + 2'd2;
			end
			if (gen_key_run == 0) begin
				gen_key = ~gen_key;
				gen_key_run = $urandom_range(1, 60);
			end
			gen_key_run--;
			tv = $urandom_range(0, 99) < gen_read_pct;
			tb = $urandom_range(0, 99) < 30;
			tick_queue.push_back(make_tick(gen_phase, gen_key, tv, tb));
		end
	endtask

	initial begin
		int shifts[8]    = '{0, 1, 2, 3, 2, 1, 0, 2};
		int intervals[8] = '{0, 1, 1023, 5, 2, 7, 20, 0};
		int counts[8]    = '{150, 200, 300, 150, 200, 200, 150, 175};
		int tx_maxes[8]  = '{13, 0, 13, 3, 13, 13, 0, 13};
		int rx_maxes[8]  = '{13, 0, 13, 13, 0, 13, 0, 13};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: steps both ways, a half-turn jump, button held at tick 20
		tick_queue.push_back(make_tick(2'd0, 1'b0, 1'b1, 1'b1));
		tick_queue.push_back(make_tick(2'd1, 1'b0, 1'b0, 1'b0));
		tick_queue.push_back(make_tick(2'd2, 1'b0, 1'b1, 1'b0));
		tick_queue.push_back(make_tick(2'd3, 1'b0, 1'b0, 1'b0));
		tick_queue.push_back(make_tick(2'd0, 1'b0, 1'b0, 1'b0));
		tick_queue.push_back(make_tick(2'd2, 1'b0, 1'b1, 1'b0));
		tick_queue.push_back(make_tick(2'd3, 1'b0, 1'b0, 1'b0));
		tick_queue.push_back(make_tick(2'd2, 1'b0, 1'b0, 1'b0));
		tick_queue.push_back(make_tick(2'd1, 1'b0, 1'b1, 1'b0));
		for (int i = 10; i <= 20; i++)
			tick_queue.push_back(make_tick(2'd0, 1'b1, 1'b0, 1'b1));
		for (int i = 21; i <= 25; i++)
			tick_queue.push_back(make_tick(2'(i), 1'b0, 1'b1, 1'b1));
		tx_max = 13;
		rx_max = 13;
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			apply_settings(SHIFT_W'(shifts[p]), INTERVAL_W'(intervals[p]));
			tx_max = tx_maxes[p];
			rx_max = rx_maxes[p];
			@(negedge clk);
			queue_random_ticks(counts[p]);
			wait_drained();
		end

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
